/* rtl/assert_macros.svh */
// Assertion macros used by the top level RTL file of the latch bank mapper.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define DLBM_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define DLBM_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/dlbm_pkg.sv */
// Package for the latch bank mapper: types, register and variant codes, bank helpers.
`timescale 1ns / 1ps

package dlbm_pkg;

	localparam int BANK_BITS = 9;

	typedef logic [BANK_BITS-1:0] bank_t;

	localparam bank_t LAST_BANK = '1;

	// Mirroring modes
	typedef enum logic [2:0] {
		MIR_H  = 3'd0,
		MIR_V  = 3'd1,
		MIR_A  = 3'd2,
		MIR_B  = 3'd3,
		MIR_HW = 3'd4
	} mir_t;

	// Configuration register indexes
	localparam logic [2:0] CFG_VARIANT     = 3'd0;
	localparam logic [2:0] CFG_LATCH_RESET = 3'd1;
	localparam logic [2:0] CFG_WIN_LOW     = 3'd2;
	localparam logic [2:0] CFG_WIN_HIGH    = 3'd3;
	localparam logic [2:0] CFG_BUS_CONFL   = 3'd4;
	localparam logic [2:0] CFG_PRG_WIDE    = 3'd5;

	// Input function codes
	localparam logic FUNC_WRITE    = 1'b0;
	localparam logic FUNC_POWER_ON = 1'b1;

	// Latch decoding variants
	localparam logic [4:0] VAR_UNROM = 5'd0;
	localparam logic [4:0] VAR_CNROM = 5'd1;
	localparam logic [4:0] VAR_AXROM = 5'd2;
	localparam logic [4:0] VAR_M03   = 5'd3;
	localparam logic [4:0] VAR_M04   = 5'd4;
	localparam logic [4:0] VAR_M05   = 5'd5;
	localparam logic [4:0] VAR_M06   = 5'd6;
	localparam logic [4:0] VAR_M07   = 5'd7;
	localparam logic [4:0] VAR_M08   = 5'd8;
	localparam logic [4:0] VAR_M09   = 5'd9;
	localparam logic [4:0] VAR_M10   = 5'd10;
	localparam logic [4:0] VAR_M11   = 5'd11;
	localparam logic [4:0] VAR_M12   = 5'd12;
	localparam logic [4:0] VAR_M13   = 5'd13;
	localparam logic [4:0] VAR_M14   = 5'd14;
	localparam logic [4:0] VAR_M15   = 5'd15;
	localparam logic [4:0] VAR_M16   = 5'd16;
	localparam logic [4:0] VAR_M17   = 5'd17;
	localparam logic [4:0] VAR_M18   = 5'd18;
	localparam logic [4:0] VAR_M19   = 5'd19;
	localparam logic [4:0] VAR_M20   = 5'd20;
	localparam logic [4:0] VAR_M21   = 5'd21;
	localparam logic [4:0] VAR_M22   = 5'd22;
	localparam logic [4:0] VAR_M23   = 5'd23;
	localparam logic [4:0] VAR_M24   = 5'd24;
	localparam logic [4:0] VAR_M25   = 5'd25;
	localparam logic [4:0] VAR_M26   = 5'd26;
	localparam logic [4:0] VAR_M27   = 5'd27;

	// Decoder result handed back to the top level
	typedef struct packed {
		bank_t prg_lo;
		bank_t prg_hi;
		bank_t chr_lo;
		bank_t chr_hi;
		mir_t  mir;
		logic  sticky;
	} dec_t;

	// Plain bank number from a select, zero-extended to the bank width
	function automatic bank_t bank_of(input logic [7:0] sel);
		return BANK_BITS'(sel);
	endfunction

	// Even half of a double-size select
	function automatic bank_t pair_even(input logic [7:0] sel);
		return BANK_BITS'({sel, 1'b0});
	endfunction

	// Odd half of a double-size select
	function automatic bank_t pair_odd(input logic [7:0] sel);
		return BANK_BITS'({sel, 1'b1});
	endfunction

endpackage

/* rtl/dlbm_decode.sv */
// Latch decoder: bank numbers and mirroring for every variant.
`timescale 1ns / 1ps

module dlbm_decode
	import dlbm_pkg::*;
(
	input  logic [4:0] variant,
	input  logic       prg_wide,
	input  logic [7:0] latch,
	input  mir_t       mir_cur,
	input  logic       sticky_cur,
	output dec_t       dec
);

	logic [7:0] l;
	logic       st_set;

	assign l      = latch;
	assign st_set = sticky_cur | l[3];

	// Decode latch into banks; mirroring and sticky assume a load
	always_comb begin
		dec.prg_lo = '0;
		dec.prg_hi = LAST_BANK;
		dec.chr_lo = pair_even(8'd0);
		dec.chr_hi = pair_odd(8'd0);
		dec.mir    = mir_cur;
		dec.sticky = sticky_cur;
		case (variant)
			VAR_UNROM: begin
				if (prg_wide) begin
					dec.prg_lo = bank_of(8'(l[3:0]));
				end else begin
					dec.prg_lo = bank_of(8'(l[2:0]));
					dec.sticky = st_set;
					if (st_set) begin
						dec.mir = l[3] ? MIR_H : MIR_V;
					end
				end
			end
			VAR_CNROM: begin
				dec.prg_lo = pair_even(8'd0);
				dec.prg_hi = pair_odd(8'd0);
				dec.chr_lo = pair_even(l);
				dec.chr_hi = pair_odd(l);
			end
			VAR_AXROM: begin
				dec.prg_lo = pair_even(8'(l[3:0]));
				dec.prg_hi = pair_odd(8'(l[3:0]));
				dec.mir    = l[4] ? MIR_B : MIR_A;
			end
			VAR_M03: begin
				dec.prg_lo = bank_of(8'(l[7:3]));
				dec.prg_hi = bank_of(8'd1);
				dec.chr_lo = pair_even(8'(l[1:0]));
				dec.chr_hi = pair_odd(8'(l[1:0]));
			end
			VAR_M04: begin
				dec.prg_lo = pair_even(8'(l[3:0]));
				dec.prg_hi = pair_odd(8'(l[3:0]));
				dec.chr_lo = pair_even(8'(l[7:4]));
				dec.chr_hi = pair_odd(8'(l[7:4]));
			end
			VAR_M05: begin
				dec.prg_lo = pair_even(8'd0);
				dec.prg_hi = pair_odd(8'd0);
				dec.chr_lo = bank_of(8'd0);
				dec.chr_hi = bank_of(8'(l[1:0]));
			end
			VAR_M06, VAR_M08, VAR_M24: begin
				dec.prg_lo = pair_even(8'(l[7:4]));
				dec.prg_hi = pair_odd(8'(l[7:4]));
				dec.chr_lo = pair_even(8'(l[3:0]));
				dec.chr_hi = pair_odd(8'(l[3:0]));
			end
			VAR_M07: begin
				dec.prg_lo = pair_even(8'(l[1:0]));
				dec.prg_hi = pair_odd(8'(l[1:0]));
				dec.chr_lo = pair_even(8'(l[7:2]));
				dec.chr_hi = pair_odd(8'(l[7:2]));
			end
			VAR_M09: begin
				dec.prg_lo = bank_of(8'(l[7:4]));
				dec.chr_lo = pair_even(8'(l[3:0]));
				dec.chr_hi = pair_odd(8'(l[3:0]));
			end
			VAR_M10: begin
				dec.prg_lo = bank_of(8'(l[2:0]));
				dec.chr_lo = pair_even(8'(l[7:4]));
				dec.chr_hi = pair_odd(8'(l[7:4]));
				dec.mir    = l[3] ? MIR_B : MIR_A;
			end
			VAR_M11: begin
				dec.prg_lo = pair_even(8'(l[5:4]));
				dec.prg_hi = pair_odd(8'(l[5:4]));
				dec.chr_lo = pair_even(8'({l[6], l[1:0]}));
				dec.chr_hi = pair_odd(8'({l[6], l[1:0]}));
			end
			VAR_M12: begin
				dec.prg_lo = pair_even(8'd0);
				dec.prg_hi = pair_odd(8'd0);
				dec.chr_lo = pair_even(8'({l[0], l[1]}));
				dec.chr_hi = pair_odd(8'({l[0], l[1]}));
			end
			VAR_M13: begin
				dec.prg_lo = bank_of(8'(l[6:4]));
				dec.chr_lo = pair_even(8'({l[7], l[2:0]}));
				dec.chr_hi = pair_odd(8'({l[7], l[2:0]}));
				dec.mir    = l[3] ? MIR_B : MIR_A;
			end
			VAR_M14: begin
				dec.prg_lo = bank_of(8'(l[7:4]));
			end
			VAR_M15: begin
				dec.prg_lo = bank_of(8'(l[7:2]));
			end
			VAR_M16: begin
				dec.prg_lo = LAST_BANK;
				dec.prg_hi = bank_of(8'(l[3:0]));
				dec.chr_lo = pair_even(8'({l[0], l[1]}));
				dec.chr_hi = pair_odd(8'({l[0], l[1]}));
				if (l[7:6] == 2'b01) begin
					dec.mir = MIR_H;
				end else if (l[7:6] == 2'b10) begin
					dec.mir = MIR_V;
				end
			end
			VAR_M17: begin
				dec.prg_lo = pair_even(8'd0);
				dec.prg_hi = pair_odd(8'd0);
				dec.chr_lo = pair_even(l);
				dec.chr_hi = pair_odd(l);
			end
			VAR_M18: begin
				dec.prg_lo = pair_even(8'(l[2:1]));
				dec.prg_hi = pair_odd(8'(l[2:1]));
				dec.chr_lo = pair_even(8'(l[2:0]));
				dec.chr_hi = pair_odd(8'(l[2:0]));
			end
			VAR_M19: begin
				dec.prg_lo = pair_even(8'(l[5:3]));
				dec.prg_hi = pair_odd(8'(l[5:3]));
				dec.chr_lo = pair_even(8'({l[6], l[2:0]}));
				dec.chr_hi = pair_odd(8'({l[6], l[2:0]}));
			end
			VAR_M20: begin
				dec.prg_lo = bank_of(8'(l[6:4]));
				dec.chr_lo = pair_even(8'(l[3:0]));
				dec.chr_hi = pair_odd(8'(l[3:0]));
				dec.mir    = l[7] ? MIR_B : MIR_A;
			end
			VAR_M21: begin
				dec.prg_lo = bank_of(8'd0);
				dec.prg_hi = bank_of(l);
			end
			VAR_M22: begin
				dec.prg_lo = pair_even(8'd0);
				dec.prg_hi = pair_odd(8'd0);
				dec.chr_lo = bank_of(l);
				dec.chr_hi = bank_of(8'(l[7:4]));
			end
			VAR_M23: begin
				dec.prg_lo = bank_of(8'(l[3:2]));
				dec.prg_hi = bank_of(8'(l[3:2]));
				dec.chr_lo = pair_even(8'(l[1:0]));
				dec.chr_hi = pair_odd(8'(l[1:0]));
			end
			VAR_M25: begin
				dec.prg_lo = pair_even(l);
				dec.prg_hi = pair_odd(l);
			end
			VAR_M26: begin
				if (l[6]) begin
					dec.prg_lo = pair_even(8'(l[4:1]));
					dec.prg_hi = pair_odd(8'(l[4:1]));
				end else begin
					dec.prg_lo = bank_of(8'({l[5:4], l[2:0]}));
					dec.prg_hi = bank_of(8'({l[5:4], 3'b111}));
				end
				if (l[7]) begin
					dec.mir = l[5] ? MIR_B : MIR_A;
				end else begin
					dec.mir = l[3] ? MIR_H : MIR_V;
				end
			end
			VAR_M27: begin
				dec.prg_lo = pair_even(8'(l[6:4]));
				dec.prg_hi = pair_odd(8'(l[6:4]));
				dec.chr_lo = pair_even(8'({l[6:4], l[1:0]}));
				dec.chr_hi = pair_odd(8'({l[6:4], l[1:0]}));
				dec.mir    = l[7] ? MIR_V : MIR_H;
			end
			default: begin
				// unused variant: first and last program bank, pattern banks 0 and 1
				dec.prg_lo = bank_of(8'd0);
				dec.prg_hi = LAST_BANK;
			end
		endcase
	end

endmodule

/* rtl/discrete_latch_bank_mapper.sv */
// Top level of the discrete latch bank mapper: beat registers, latch state and result register.
`timescale 1ns / 1ps

// Discrete latch bank mapper. Each input beat (a CPU write or a power-on reload)
// gives exactly one result beat holding the 16KB program banks, the 4KB pattern
// banks, the mirroring mode and the latch after that beat. The block takes one
// beat per cycle while not stalled: a beat is captured in an input register,
// decoded by shallow bit selection and written to the result register. Throughput
// is one beat per cycle when not stalled, set by the single result register; a
// stall on the result side holds the input side once the input register is full.
// The user must write configuration registers only while the block is idle; the
// block itself does not enforce this.
`include "assert_macros.svh"

module discrete_latch_bank_mapper
	import dlbm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_write,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// input beats
	input  logic        item_valid,
	output logic        item_stall,
	input  logic        func,
	input  logic [15:0] cpu_address,
	input  logic [7:0]  write_data,
	input  logic [7:0]  rom_byte,
	// result beats
	output logic        result_valid,
	input  logic        result_stall,
	output bank_t       prg_bank_low,
	output bank_t       prg_bank_high,
	output bank_t       chr_bank_low,
	output bank_t       chr_bank_high,
	output logic [2:0]  mirroring,
	output logic [7:0]  latch_value
);

	// configuration registers
	logic [4:0]  variant_q;
	logic [7:0]  latch_rst_q;
	logic [15:0] win_low_q;
	logic [15:0] win_high_q;
	logic        bus_confl_q;
	logic        prg_wide_q;

	// input register
	logic        vld_s1;
	logic        func_s1;
	logic [15:0] addr_s1;
	logic [7:0]  data_s1;
	logic [7:0]  rom_s1;

	// mapper state
	logic [7:0]  latch_q;
	mir_t        mirror_q;
	logic        sticky_q;

	// result register
	logic        vld_s2;
	bank_t       prg_lo_s2;
	bank_t       prg_hi_s2;
	bank_t       chr_lo_s2;
	bank_t       chr_hi_s2;
	mir_t        mir_s2;
	logic [7:0]  latch_s2;

	logic        adv;
	logic        take;
	logic        in_win;
	logic        load;
	logic [7:0]  latch_nxt;
	mir_t        mir_nxt;
	dec_t        dec;

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			variant_q   <= VAR_UNROM;
			latch_rst_q <= 8'h00;
			win_low_q   <= 16'h8000;
			win_high_q  <= 16'hFFFF;
			bus_confl_q <= 1'b0;
			prg_wide_q  <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_VARIANT:     variant_q   <= cfg_data[4:0];
				CFG_LATCH_RESET: latch_rst_q <= cfg_data[7:0];
				CFG_WIN_LOW:     win_low_q   <= cfg_data;
				CFG_WIN_HIGH:    win_high_q  <= cfg_data;
				CFG_BUS_CONFL:   bus_confl_q <= cfg_data[0];
				CFG_PRG_WIDE:    prg_wide_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// advance a held beat when the result register is free or being drained
	assign adv        = vld_s1 && (!vld_s2 || !result_stall);
	assign item_stall = vld_s1 && !adv;
	assign take       = item_valid && !item_stall;

	// capture input beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (take) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			func_s1 <= func;
			addr_s1 <= cpu_address;
			data_s1 <= write_data;
			rom_s1  <= rom_byte;
		end
	end

	// decide whether this beat loads the latch, and with what
	assign in_win = (addr_s1 >= win_low_q) && (addr_s1 <= win_high_q);
	assign load   = (func_s1 == FUNC_POWER_ON) || in_win;

	always_comb begin
		if (func_s1 == FUNC_POWER_ON) begin
			latch_nxt = latch_rst_q;
		end else if (in_win) begin
			latch_nxt = bus_confl_q ? (data_s1 & rom_s1) : data_s1;
		end else begin
			latch_nxt = latch_q;
		end
	end

	dlbm_decode u_decode (
		.variant    (variant_q),
		.prg_wide   (prg_wide_q),
		.latch      (latch_nxt),
		.mir_cur    (mirror_q),
		.sticky_cur (sticky_q),
		.dec        (dec)
	);

	// hold the mirroring on a beat that loads nothing
	assign mir_nxt = load ? dec.mir : mirror_q;

	// update mapper state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latch_q  <= 8'h00;
			mirror_q <= MIR_HW;
			sticky_q <= 1'b0;
		end else if (adv) begin
			latch_q  <= latch_nxt;
			mirror_q <= mir_nxt;
			if (load) begin
				sticky_q <= dec.sticky;
			end
		end
	end

	// hold or load result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= 1'b1;
		end else if (!result_stall) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prg_lo_s2 <= dec.prg_lo;
			prg_hi_s2 <= dec.prg_hi;
			chr_lo_s2 <= dec.chr_lo;
			chr_hi_s2 <= dec.chr_hi;
			mir_s2    <= mir_nxt;
			latch_s2  <= latch_nxt;
		end
	end

	assign result_valid  = vld_s2;
	assign prg_bank_low  = prg_lo_s2;
	assign prg_bank_high = prg_hi_s2;
	assign chr_bank_low  = chr_lo_s2;
	assign chr_bank_high = chr_hi_s2;
	assign mirroring     = mir_s2;
	assign latch_value   = latch_s2;

	// sticky mirroring enable never clears outside reset
	`DLBM_ASSERT_NXT(a_sticky_holds, sticky_q, sticky_q, "sticky mirroring cleared")

	// latch moves only when a beat advances
	`DLBM_ASSERT_NXT(a_latch_idle, !adv, $stable(latch_q), "latch changed without a beat")

	// a beat that loads nothing leaves the mirroring alone
	`DLBM_ASSERT_NXT(a_mir_no_load, adv && !load, mirror_q == $past(mirror_q),
		"mirroring changed without a latch load")

	// an advancing beat always lands in the result register
	`DLBM_ASSERT_NXT(a_result_lands, adv, vld_s2 && (latch_s2 == latch_q),
		"advanced beat missing from result")

endmodule

/* test/dlbm_checker.sv */
// Checker for the latch bank mapper: follows configuration, predicts each result beat and compares.
`timescale 1ns / 1ps

module dlbm_checker
	import dlbm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        item_valid,
	input  logic        item_stall,
	input  logic        func,
	input  logic [15:0] cpu_address,
	input  logic [7:0]  write_data,
	input  logic [7:0]  rom_byte,
	input  logic        result_valid,
	input  logic        result_stall,
	input  bank_t       prg_bank_low,
	input  bank_t       prg_bank_high,
	input  bank_t       chr_bank_low,
	input  bank_t       chr_bank_high,
	input  logic [2:0]  mirroring,
	input  logic [7:0]  latch_value,
	input  logic        end_check,
	output int          failures
);

	typedef struct packed {
		bank_t      prg_lo;
		bank_t      prg_hi;
		bank_t      chr_lo;
		bank_t      chr_hi;
		logic [2:0] mir;
		logic [7:0] latch;
	} map_beat_t;

	// Configuration as seen on the write port
	logic [4:0]  variant_sel;
	logic [7:0]  reload_value;
	logic [15:0] win_low;
	logic [15:0] win_high;
	logic        and_with_rom;
	logic        prg_wide;

	// Mapper state
	logic [7:0]  latch_q;
	mir_t        mirror_q;
	logic        sticky_q;

	map_beat_t   expected_maps[$];
	map_beat_t   want;
	logic [7:0]  next_latch;
	logic        loaded;
	logic        next_sticky;
	bit          end_reported;

	// Even and odd bank of a double-size select
	function automatic logic [2*BANK_BITS-1:0] bank_pair(input int sel);
		return {bank_t'(2 * sel), bank_t'(2 * sel + 1)};
	endfunction

	// Decode a latch value into banks; mirroring and the sticky flag move only on a load
	function automatic map_beat_t decode_latch(input logic [7:0] l, input logic [4:0] sel,
			input logic wide, input logic load, input mir_t mir_in, input logic sticky_in,
			output logic sticky_out);
		map_beat_t r;
		mir_t      m;
		logic [2:0] b;
		m = mir_in;
		sticky_out = sticky_in;
		r.latch = l;
		// variants that do not override them keep pattern banks 0/1 and the last program bank on top
		{r.chr_lo, r.chr_hi} = bank_pair(0);
		r.prg_lo = '0;
		r.prg_hi = LAST_BANK;
		case (sel)
			VAR_UNROM: begin
				if (wide) begin
					r.prg_lo = bank_t'(l & 8'h0f);
				end else begin
					r.prg_lo = bank_t'(l & 8'h07);
					if (load && l[3]) sticky_out = 1'b1;
					if (load && sticky_out) m = l[3] ? MIR_H : MIR_V;
				end
			end
			VAR_CNROM: begin
				{r.chr_lo, r.chr_hi} = bank_pair(l);
				{r.prg_lo, r.prg_hi} = bank_pair(0);
			end
			VAR_AXROM: begin
				{r.prg_lo, r.prg_hi} = bank_pair(l & 8'h0f);
				m = l[4] ? MIR_B : MIR_A;
			end
			VAR_M03: begin
				r.prg_lo = bank_t'(l >> 3);
				r.prg_hi = bank_t'(1);
				{r.chr_lo, r.chr_hi} = bank_pair(l & 8'h03);
			end
			VAR_M04: begin
				{r.prg_lo, r.prg_hi} = bank_pair(l & 8'h0f);
				{r.chr_lo, r.chr_hi} = bank_pair(l >> 4);
			end
			VAR_M05: begin
				r.chr_lo = '0;
				r.chr_hi = bank_t'(l & 8'h03);
				{r.prg_lo, r.prg_hi} = bank_pair(0);
			end
			VAR_M06, VAR_M08, VAR_M24: begin
				{r.prg_lo, r.prg_hi} = bank_pair(l >> 4);
				{r.chr_lo, r.chr_hi} = bank_pair(l & 8'h0f);
			end
			VAR_M07: begin
				{r.prg_lo, r.prg_hi} = bank_pair(l & 8'h03);
				{r.chr_lo, r.chr_hi} = bank_pair(l >> 2);
			end
			VAR_M09: begin
				r.prg_lo = bank_t'(l >> 4);
				{r.chr_lo, r.chr_hi} = bank_pair(l & 8'h0f);
			end
			VAR_M10: begin
				r.prg_lo = bank_t'(l & 8'h07);
				{r.chr_lo, r.chr_hi} = bank_pair(l >> 4);
				m = l[3] ? MIR_B : MIR_A;
			end
			VAR_M11: begin
				{r.prg_lo, r.prg_hi} = bank_pair((l >> 4) & 8'h03);
				{r.chr_lo, r.chr_hi} = bank_pair((l & 8'h03) | ((l >> 4) & 8'h04));
			end
			VAR_M12: begin
				{r.prg_lo, r.prg_hi} = bank_pair(0);
				{r.chr_lo, r.chr_hi} = bank_pair({l[0], l[1]});
			end
			VAR_M13: begin
				r.prg_lo = bank_t'((l >> 4) & 8'h07);
				{r.chr_lo, r.chr_hi} = bank_pair((l & 8'h07) | ((l >> 4) & 8'h08));
				m = l[3] ? MIR_B : MIR_A;
			end
			VAR_M14: r.prg_lo = bank_t'(l >> 4);
			VAR_M15: r.prg_lo = bank_t'(l >> 2);
			VAR_M16: begin
				r.prg_lo = LAST_BANK;
				r.prg_hi = bank_t'(l & 8'h0f);
				if (l[7:6] == 2'b01) m = MIR_H;
				else if (l[7:6] == 2'b10) m = MIR_V;
				{r.chr_lo, r.chr_hi} = bank_pair({l[0], l[1]});
			end
			VAR_M17: begin
				{r.prg_lo, r.prg_hi} = bank_pair(0);
				{r.chr_lo, r.chr_hi} = bank_pair(l);
			end
			VAR_M18: begin
				{r.prg_lo, r.prg_hi} = bank_pair((l >> 1) & 8'h03);
				{r.chr_lo, r.chr_hi} = bank_pair(l & 8'h07);
			end
			VAR_M19: begin
				{r.prg_lo, r.prg_hi} = bank_pair((l >> 3) & 8'h07);
				{r.chr_lo, r.chr_hi} = bank_pair(((l >> 3) & 8'h08) | (l & 8'h07));
			end
			VAR_M20: begin
				r.prg_lo = bank_t'((l >> 4) & 8'h07);
				{r.chr_lo, r.chr_hi} = bank_pair(l & 8'h0f);
				m = l[7] ? MIR_B : MIR_A;
			end
			VAR_M21: r.prg_hi = bank_t'(l);
			VAR_M22: begin
				r.chr_lo = bank_t'(l);
				r.chr_hi = bank_t'(l >> 4);
				{r.prg_lo, r.prg_hi} = bank_pair(0);
			end
			VAR_M23: begin
				r.prg_lo = bank_t'((l >> 2) & 8'h03);
				r.prg_hi = bank_t'((l >> 2) & 8'h03);
				{r.chr_lo, r.chr_hi} = bank_pair(l & 8'h03);
			end
			VAR_M25: {r.prg_lo, r.prg_hi} = bank_pair(l);
			VAR_M26: begin
				if (l[6]) begin
					{r.prg_lo, r.prg_hi} = bank_pair((l >> 1) & 8'h0f);
				end else begin
					r.prg_lo = bank_t'(((l & 8'h30) >> 1) | (l & 8'h07));
					r.prg_hi = bank_t'(((l & 8'h30) >> 1) | 8'h07);
				end
				if (l[7]) m = l[5] ? MIR_B : MIR_A;
				else m = l[3] ? MIR_H : MIR_V;
			end
			VAR_M27: begin
				b = l[6:4];
				{r.prg_lo, r.prg_hi} = bank_pair(b);
				{r.chr_lo, r.chr_hi} = bank_pair({b, l[1:0]});
				m = l[7] ? MIR_V : MIR_H;
			end
			default: ;
		endcase
		r.mir = load ? m : mir_in;
		return r;
	endfunction

	// Count and report a field mismatch
	task automatic check_field(input string name, input int exp_val, input int act_val);
		if (exp_val != act_val) begin
			$error("%s: expected %0d, got %0d", name, exp_val, act_val);
			failures++;
		end
	endtask

	// Follow configuration, compare result beats, predict input beats
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			variant_sel = VAR_UNROM;
			reload_value = '0;
			win_low = 16'h8000;
			win_high = 16'hffff;
			and_with_rom = 1'b0;
			prg_wide = 1'b0;
			latch_q = '0;
			mirror_q = MIR_HW;
			sticky_q = 1'b0;
			expected_maps.delete();
			end_reported = 1'b0;
			failures = 0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					CFG_VARIANT:     variant_sel = cfg_data[4:0];
					CFG_LATCH_RESET: reload_value = cfg_data[7:0];
					CFG_WIN_LOW:     win_low = cfg_data;
					CFG_WIN_HIGH:    win_high = cfg_data;
					CFG_BUS_CONFL:   and_with_rom = cfg_data[0];
					CFG_PRG_WIDE:    prg_wide = cfg_data[0];
					default: ;
				endcase
			end

			// compare against the oldest expectation
			if (result_valid && !result_stall) begin
				if (expected_maps.size() == 0) begin
					$error("result beat with no expectation pending");
					failures++;
				end else begin
					want = expected_maps.pop_front();
					check_field("prg_bank_low", want.prg_lo, prg_bank_low);
					check_field("prg_bank_high", want.prg_hi, prg_bank_high);
					check_field("chr_bank_low", want.chr_lo, chr_bank_low);
					check_field("chr_bank_high", want.chr_hi, chr_bank_high);
					check_field("mirroring", want.mir, mirroring);
					check_field("latch_value", want.latch, latch_value);
				end
			end

			// advance the latch and queue the expected map
			if (item_valid && !item_stall) begin
				loaded = 1'b1;
				if (func == FUNC_POWER_ON)
					next_latch = reload_value;
				else if (cpu_address >= win_low && cpu_address <= win_high)
					next_latch = and_with_rom ? (write_data & rom_byte) : write_data;
				else begin
					next_latch = latch_q;
					loaded = 1'b0;
				end
				want = decode_latch(next_latch, variant_sel, prg_wide, loaded, mirror_q,
					sticky_q, next_sticky);
				latch_q = next_latch;
				mirror_q = mir_t'(want.mir);
				sticky_q = next_sticky;
				expected_maps.push_back(want);
			end

			// flag expectations left over at the end
			if (end_check && !end_reported) begin
				if (expected_maps.size() != 0) begin
					$error("%0d result beats never arrived", expected_maps.size());
					failures++;
				end
				end_reported = 1'b1;
			end
		end
	end

endmodule

/* test/tb_discrete_latch_bank_mapper.sv */
// Testbench top for the latch bank mapper: clock, reset, stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_discrete_latch_bank_mapper;
	import dlbm_pkg::*;

	// beyond the last defined variant
	localparam logic [4:0] VAR_SPARE_TOP = 5'd31;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_write = 1'b0;
	logic [2:0]  cfg_index = CFG_VARIANT;
	logic [15:0] cfg_data = '0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	logic        func = FUNC_WRITE;
	logic [15:0] cpu_address = '0;
	logic [7:0]  write_data = '0;
	logic [7:0]  rom_byte = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	bank_t       prg_bank_low;
	bank_t       prg_bank_high;
	bank_t       chr_bank_low;
	bank_t       chr_bank_high;
	logic [2:0]  mirroring;
	logic [7:0]  latch_value;
	logic        end_check = 1'b0;
	int          failures;

	int          tx_idle_pct = 0;
	int          rx_idle_pct = 0;
	int          beats_sent = 0;
	int          beats_taken = 0;
	int          hold_left = 0;
	bit          hold_done = 1'b0;
	logic [15:0] win_lo = 16'h8000;
	logic [15:0] win_hi = 16'hffff;

	always #5 clk = ~clk;

	discrete_latch_bank_mapper u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.item_valid(item_valid), .item_stall(item_stall),
		.func(func), .cpu_address(cpu_address), .write_data(write_data), .rom_byte(rom_byte),
		.result_valid(result_valid), .result_stall(result_stall),
		.prg_bank_low(prg_bank_low), .prg_bank_high(prg_bank_high),
		.chr_bank_low(chr_bank_low), .chr_bank_high(chr_bank_high),
		.mirroring(mirroring), .latch_value(latch_value)
	);

	dlbm_checker u_check (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.item_valid(item_valid), .item_stall(item_stall),
		.func(func), .cpu_address(cpu_address), .write_data(write_data), .rom_byte(rom_byte),
		.result_valid(result_valid), .result_stall(result_stall),
		.prg_bank_low(prg_bank_low), .prg_bank_high(prg_bank_high),
		.chr_bank_low(chr_bank_low), .chr_bank_high(chr_bank_high),
		.mirroring(mirroring), .latch_value(latch_value),
		.end_check(end_check), .failures(failures)
	);

	// Result side: random stalls, plus one long hold-off to back the block up
	always @(negedge clk) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else if (hold_left > 0) begin
			result_stall <= 1'b1;
			hold_left--;
		end else if (!hold_done && beats_sent >= 300) begin
			result_stall <= 1'b1;
			hold_left = 63;
			hold_done = 1'b1;
		end else begin
			result_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	// Count result beats taken
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) beats_taken++;
	end

	// Write one register, leaving the enable high for a following write
	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
	endtask

	task automatic set_config(input logic [4:0] var_sel, input logic [7:0] reload,
			input logic [15:0] lo, input logic [15:0] hi, input logic conflict,
			input logic wide);
		write_reg(CFG_VARIANT, 16'(var_sel));
		write_reg(CFG_LATCH_RESET, 16'(reload));
		write_reg(CFG_WIN_LOW, lo);
		write_reg(CFG_WIN_HIGH, hi);
		write_reg(CFG_BUS_CONFL, 16'(conflict));
		write_reg(CFG_PRG_WIDE, 16'(wide));
		cfg_write <= 1'b0;
		win_lo = lo;
		win_hi = hi;
	endtask

	// Offer one beat after a random gap and hold it until taken
	task automatic send_beat(input logic f, input logic [15:0] addr, input logic [7:0] data,
			input logic [7:0] rom);
		while ($urandom_range(99) < tx_idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		func <= f;
		cpu_address <= addr;
		write_data <= data;
		rom_byte <= rom;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		@(negedge clk);
		beats_sent++;
	endtask

	// Mostly writes inside the window, some at its edges, some anywhere, a few reloads
	task automatic send_random();
		logic [15:0] addr;
		int          pick;
		pick = $urandom_range(99);
		addr = 16'($urandom);
		if (pick < 6) begin
			send_beat(FUNC_POWER_ON, addr, 8'($urandom), 8'($urandom));
		end else begin
			if (pick < 80 && win_lo <= win_hi) begin
				addr = 16'($urandom_range(win_hi, win_lo));
			end else if (pick < 90) begin
				case ($urandom_range(3))
					0: addr = win_lo;
					1: addr = win_hi;
					2: addr = 16'h0000;
					default: addr = 16'hffff;
				endcase
			end
			send_beat(FUNC_WRITE, addr, 8'($urandom),
				($urandom_range(3) == 0) ? 8'hff : 8'($urandom));
		end
	endtask

	// Drop valid and wait until every result beat is back
	task automatic drain();
		item_valid <= 1'b0;
		@(negedge clk);
		while (beats_taken < beats_sent) @(negedge clk);
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		tx_idle_pct = 18;
		rx_idle_pct = 50;

		// Reset configuration: window edges, outside writes, sticky mirroring, reload
		send_beat(FUNC_WRITE, 16'h8000, 8'h00, 8'hff);
		send_beat(FUNC_WRITE, 16'h7fff, 8'hff, 8'hff);
		send_beat(FUNC_WRITE, 16'h0000, 8'ha5, 8'h00);
		send_beat(FUNC_WRITE, 16'hffff, 8'h07, 8'h00);
		send_beat(FUNC_WRITE, 16'hffff, 8'h0f, 8'h00);
		send_beat(FUNC_WRITE, 16'hc000, 8'h07, 8'h00);
		send_beat(FUNC_POWER_ON, 16'hffff, 8'hff, 8'hff);
		drain();

		// Empty window with the wide program decoding
		set_config(VAR_UNROM, 8'hff, 16'h9000, 16'h8fff, 1'b1, 1'b1);
		send_beat(FUNC_WRITE, 16'h9000, 8'hff, 8'hff);
		send_beat(FUNC_WRITE, 16'h8fff, 8'hff, 8'hff);
		send_beat(FUNC_POWER_ON, 16'h0000, 8'h00, 8'h00);
		drain();

		// One-address window with bus conflicts
		set_config(VAR_AXROM, 8'h10, 16'ha5a5, 16'ha5a5, 1'b1, 1'b0);
		send_beat(FUNC_WRITE, 16'ha5a5, 8'hff, 8'h5a);
		send_beat(FUNC_WRITE, 16'ha5a4, 8'hff, 8'hff);
		send_beat(FUNC_WRITE, 16'ha5a6, 8'hff, 8'hff);
		send_beat(FUNC_WRITE, 16'ha5a5, 8'h1f, 8'hef);
		drain();

		// Both program layouts and every mirroring rule of the multi-mode variant
		set_config(VAR_M26, 8'h00, 16'h0000, 16'hffff, 1'b0, 1'b0);
		send_beat(FUNC_WRITE, 16'h8000, 8'h40, 8'h00);
		send_beat(FUNC_WRITE, 16'h8000, 8'h80, 8'h00);
		send_beat(FUNC_WRITE, 16'h8000, 8'ha0, 8'h00);
		send_beat(FUNC_WRITE, 16'h8000, 8'h08, 8'h00);
		send_beat(FUNC_WRITE, 16'h8000, 8'h00, 8'h00);
		send_beat(FUNC_WRITE, 16'h8000, 8'h7f, 8'h00);
		drain();

		// Two-bit mirroring field: set, set, and leave unchanged
		set_config(VAR_M16, 8'h00, 16'h0000, 16'hffff, 1'b0, 1'b0);
		send_beat(FUNC_WRITE, 16'h8000, 8'h40, 8'h00);
		send_beat(FUNC_WRITE, 16'h8000, 8'h80, 8'h00);
		send_beat(FUNC_WRITE, 16'h8000, 8'hc0, 8'h00);
		drain();

		// Undefined variant
		set_config(VAR_SPARE_TOP, 8'h00, 16'h0000, 16'hffff, 1'b0, 1'b0);
		send_beat(FUNC_WRITE, 16'h8000, 8'h55, 8'h00);
		drain();

		// Random phases, one per variant code, sweeping the idle patterns
		for (int p = 0; p < 32; p++) begin
			logic [15:0] lo;
			logic [15:0] hi;
			logic [7:0]  reload;
			int          span;
			case ($urandom_range(7))
				0, 1, 2: begin
					lo = 16'h8000;
					hi = 16'hffff;
				end
				3: begin
					lo = 16'h0000;
					hi = 16'hffff;
				end
				4, 5: begin
					lo = 16'($urandom);
					span = int'(lo) + $urandom_range(4095);
					hi = (span > 65535) ? 16'hffff : 16'(span);
				end
				6: begin
					lo = 16'($urandom);
					hi = 16'($urandom);
				end
				default: begin
					lo = 16'($urandom_range(65535, 1));
					hi = 16'($urandom_range(int'(lo) - 1, 0));
				end
			endcase
			case (p % 4)
				0: reload = 8'h00;
				1: reload = 8'hff;
				default: reload = 8'($urandom);
			endcase
			if (p < 11) begin
				tx_idle_pct = 18;
				rx_idle_pct = 50;
			end else if (p < 22) begin
				tx_idle_pct = 50;
				rx_idle_pct = 18;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			set_config(5'(p), reload, lo, hi, 1'($urandom), 1'($urandom));
			repeat (44) send_random();
			drain();
		end

		// Let the pipeline settle, then collect leftovers and decide
		repeat (4) @(negedge clk);
		end_check <= 1'b1;
		repeat (2) @(negedge clk);
		if (failures == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end

endmodule

/* discrete_latch_bank_mapper.f */
+incdir+rtl
rtl/dlbm_pkg.sv
rtl/dlbm_decode.sv
rtl/discrete_latch_bank_mapper.sv
test/dlbm_checker.sv
test/tb_discrete_latch_bank_mapper.sv
